[rtl/sts_pkg.sv]
// Package for the sorted table binary search block.
// Holds the sizes, the item and memory request types and the sequencer states.
// No dependencies.
package sts_pkg;

  localparam int TableDepth = 128;
  localparam int ValueWidth = 16;
  localparam int AddrW      = $clog2(TableDepth);
  localparam int CntW       = AddrW + 1;
  localparam int PosW       = 7;
  localparam int ProbeW     = 4;
  localparam int TotalW     = 16;

  typedef logic signed [ValueWidth-1:0] val_t;
  typedef logic signed [CntW:0]         bound_t;

  typedef struct packed {
    logic               command;
    logic signed [15:0] load_value;
    logic               last_value;
    logic signed [15:0] search_key;
  } sts_in_t;

  typedef struct packed {
    logic              found;
    logic [PosW-1:0]   position;
    logic [ProbeW-1:0] probes;
    logic [TotalW-1:0] compare_total;
  } sts_out_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    val_t             wdata;
    logic [AddrW-1:0] raddr;
  } sts_mem_req_t;

  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SEARCH = 1'b1
  } sts_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT_RD,
    ST_SORT_GETV,
    ST_SORT_CMP,
    ST_SORT_PLACE,
    ST_SRCH_CMP,
    ST_SRCH_DONE
  } sts_state_e;

endpackage

[rtl/sorted_table_binary_search.sv]
// Load item: taken in idle. Search item: taken in idle, then probed (at most
// log2(depth)+1 probes), then handed off; the result shows on the output register
// the cycle after. One memory read per cycle sets the probe rate.
// Closing load: insertion sort shifts larger entries up, then places each one.
// Reset clears control state and the probe total; table contents are undefined
// until loaded and get no clearing pass.
module sorted_table_binary_search
  import sts_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  sts_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sts_out_t out_item_o
);

  sts_mem_req_t mem_req;
  val_t         rd_data;
  logic         res_valid;
  logic         res_ready;
  sts_out_t     res_item;

  logic     out_valid_q, out_valid_d;
  sts_out_t out_item_q, out_item_d;

  sts_table_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  sts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_item_o  (res_item),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  // The output register takes a new item when empty or being drained.
  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_item_d  = res_item;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[rtl/sts_table_ram.sv]
// Table storage: one write port and one read port, read data registered.
// Depends on sts_pkg.
module sts_table_ram
  import sts_pkg::*;
(
  input  logic         clk_i,
  input  sts_mem_req_t req_i,
  output val_t         rd_data_o
);

  val_t mem [TableDepth];
  val_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_data_q <= mem[req_i.raddr];
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/sts_ctrl.sv]
// Sequencer for loads, the insertion sort at table close and the binary search.
// Drives the table memory and hands one result per search to the output stage.
// Depends on sts_pkg.
module sts_ctrl
  import sts_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  sts_in_t      in_item_i,
  output logic         res_valid_o,
  input  logic         res_ready_i,
  output sts_out_t     res_item_o,
  output sts_mem_req_t mem_req_o,
  input  val_t         rd_data_i
);

  sts_state_e state_q, state_d;

  logic [CntW-1:0]   count_q, count_d;
  logic              closed_q, closed_d;
  logic [TotalW-1:0] total_q, total_d;
  logic [CntW-1:0]   i_q, i_d;
  logic [AddrW-1:0]  j_q, j_d;
  val_t              v_q, v_d;
  val_t              key_q, key_d;
  bound_t            low_q, low_d;
  bound_t            high_q, high_d;
  logic [AddrW-1:0]  mid_q, mid_d;
  logic [ProbeW-1:0] probes_q, probes_d;
  logic              hit_q, hit_d;
  logic [AddrW-1:0]  pos_q, pos_d;

  // Load bookkeeping: a load after a closed table starts from an empty one.
  logic [CntW-1:0] cnt_base;
  logic            load_fits;
  logic [CntW-1:0] load_cnt;
  logic            is_load;
  logic            is_search;

  assign is_load   = in_valid_i && (in_item_i.command == CMD_LOAD);
  assign is_search = in_valid_i && (in_item_i.command == CMD_SEARCH);
  assign cnt_base  = closed_q ? '0 : count_q;
  assign load_fits = cnt_base < CntW'(TableDepth);
  assign load_cnt  = load_fits ? cnt_base + 1'b1 : cnt_base;

  // Initial search window is 0 .. count-1.
  bound_t high_init;
  logic [CntW-1:0] mid_init_full;
  assign high_init     = $signed({1'b0, count_q}) - bound_t'(1);
  assign mid_init_full = (count_q - 1'b1) >> 1;

  // One probe: compare against the entry at mid and narrow the window.
  bound_t mid_s, new_low, new_high;
  logic [CntW+1:0] mid_sum;
  logic key_lt, key_eq, srch_more;
  logic [AddrW-1:0] mid_next;

  assign mid_s     = bound_t'({1'b0, mid_q});
  assign key_lt    = key_q < rd_data_i;
  assign key_eq    = key_q == rd_data_i;
  assign new_low   = key_lt ? low_q : mid_s + bound_t'(1);
  assign new_high  = key_lt ? mid_s - bound_t'(1) : high_q;
  assign srch_more = !key_eq && (new_high >= new_low);
  assign mid_sum   = {new_low[CntW], new_low} + {new_high[CntW], new_high};
  assign mid_next  = mid_sum[AddrW:1];

  // Sort: shift the larger neighbor up while it exceeds the held value.
  logic sort_move;
  assign sort_move = rd_data_i > v_q;

  logic [TotalW:0] total_sum;
  logic [TotalW-1:0] total_sat;
  assign total_sum = {1'b0, total_q} + (TotalW+1)'(probes_q);
  assign total_sat = total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (is_load) begin
          if (in_item_i.last_value && (load_cnt > CntW'(1))) begin
            state_d = ST_SORT_RD;
          end
        end else if (is_search) begin
          state_d = (count_q != '0) ? ST_SRCH_CMP : ST_SRCH_DONE;
        end
      end
      ST_SORT_RD:   state_d = ST_SORT_GETV;
      ST_SORT_GETV: state_d = ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (!sort_move || (j_q == AddrW'(1))) begin
          state_d = ST_SORT_PLACE;
        end
      end
      ST_SORT_PLACE: begin
        state_d = ((i_q + 1'b1) < count_q) ? ST_SORT_RD : ST_IDLE;
      end
      ST_SRCH_CMP: begin
        if (!srch_more) begin
          state_d = ST_SRCH_DONE;
        end
      end
      ST_SRCH_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: memory requests, handshakes and the result item.
  always_comb begin
    mem_req_o   = '0;
    in_ready_o  = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o      = 1'b1;
        mem_req_o.we    = is_load && load_fits;
        mem_req_o.waddr = cnt_base[AddrW-1:0];
        mem_req_o.wdata = in_item_i.load_value[ValueWidth-1:0];
        mem_req_o.raddr = mid_init_full[AddrW-1:0];
      end
      ST_SORT_RD: mem_req_o.raddr = i_q[AddrW-1:0];
      ST_SORT_GETV: mem_req_o.raddr = i_q[AddrW-1:0] - 1'b1;
      ST_SORT_CMP: begin
        mem_req_o.we    = sort_move;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = rd_data_i;
        mem_req_o.raddr = j_q - AddrW'(2);
      end
      ST_SORT_PLACE: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = v_q;
      end
      ST_SRCH_CMP: mem_req_o.raddr = mid_next;
      ST_SRCH_DONE: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    res_item_o.found         = hit_q;
    res_item_o.position      = PosW'(pos_q);
    res_item_o.probes        = probes_q;
    res_item_o.compare_total = total_sat;
  end

  // Datapath next values.
  always_comb begin
    count_d  = count_q;
    closed_d = closed_q;
    total_d  = total_q;
    i_d      = i_q;
    j_d      = j_q;
    v_d      = v_q;
    key_d    = key_q;
    low_d    = low_q;
    high_d   = high_q;
    mid_d    = mid_q;
    probes_d = probes_q;
    hit_d    = hit_q;
    pos_d    = pos_q;
    case (state_q)
      ST_IDLE: begin
        if (is_load) begin
          if (closed_q) begin
            total_d = '0;
          end
          count_d  = load_cnt;
          closed_d = in_item_i.last_value;
          i_d      = CntW'(1);
        end else if (is_search) begin
          key_d    = in_item_i.search_key[ValueWidth-1:0];
          low_d    = '0;
          high_d   = high_init;
          mid_d    = mid_init_full[AddrW-1:0];
          probes_d = '0;
          hit_d    = 1'b0;
          pos_d    = '0;
        end
      end
      ST_SORT_GETV: begin
        v_d = rd_data_i;
        j_d = i_q[AddrW-1:0];
      end
      ST_SORT_CMP: begin
        if (sort_move) begin
          j_d = j_q - 1'b1;
        end
      end
      ST_SORT_PLACE: i_d = i_q + 1'b1;
      ST_SRCH_CMP: begin
        probes_d = probes_q + 1'b1;
        low_d    = new_low;
        high_d   = new_high;
        mid_d    = mid_next;
        if (key_eq) begin
          hit_d = 1'b1;
          pos_d = mid_q;
        end
      end
      ST_SRCH_DONE: begin
        if (res_ready_i) begin
          total_d = total_sat;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      closed_q <= 1'b1;
      total_q  <= '0;
      probes_q <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      closed_q <= closed_d;
      total_q  <= total_d;
      probes_q <= probes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    j_q    <= j_d;
    v_q    <= v_d;
    key_q  <= key_d;
    low_q  <= low_d;
    high_q <= high_d;
    mid_q  <= mid_d;
    hit_q  <= hit_d;
    pos_q  <= pos_d;
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(TableDepth))
    else $error("entry count beyond table depth");

  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    probes_q <= ProbeW'(AddrW + 1))
    else $error("search made more probes than the table allows");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.we |-> (state_q == ST_IDLE || state_q == ST_SORT_CMP ||
                      state_q == ST_SORT_PLACE))
    else $error("table written outside load or sort");

  a_sort_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SORT_CMP) |-> (j_q != '0))
    else $error("sort compare with no lower neighbor");

  a_total_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH_DONE && res_ready_i) |=> (state_q == ST_IDLE))
    else $error("search result not retired after hand-off");

endmodule
